@@ hw/rtl/bpbcd_pkg.sv @@
// Shared constants, types and a helper function for the packed BCD converter.
package bpbcd_pkg;

  localparam int VALUE_W            = 64;
  localparam int COUNT_W            = 5;
  localparam int BYTE_W             = 8;
  localparam int INDEX_W            = 4;
  localparam int DIGIT_W            = 4;
  localparam int BCD_DIGITS         = 20;
  localparam int BCD_W              = BCD_DIGITS * DIGIT_W;
  localparam int BIT_CNT_W          = $clog2(VALUE_W);
  localparam int DEFAULT_MAX_DIGITS = 20;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic final_byte;
  } status_t;

  // Double dabble correction for one digit.
  function automatic logic [DIGIT_W-1:0] dabble_digit(input logic [DIGIT_W-1:0] d);
    dabble_digit = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
  endfunction

endpackage

@@ hw/rtl/bpbcd_ctrl.sv @@
// Sequencing state machine: load, 64 shift steps, then one byte per cycle.
module bpbcd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bpbcd_pkg::status_t status,
  output bpbcd_pkg::cmd_t  cmd,
  output logic             busy
);

  bpbcd_pkg::state_t state, state_next;
  logic [bpbcd_pkg::BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    unique case (state)
      bpbcd_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          bit_cnt_next = '0;
          state_next   = bpbcd_pkg::ST_SHIFT;
        end
      end
      bpbcd_pkg::ST_SHIFT: begin
        cmd.shift    = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == bpbcd_pkg::BIT_CNT_W'(bpbcd_pkg::VALUE_W - 1)) begin
          state_next = bpbcd_pkg::ST_EMIT;
        end
      end
      bpbcd_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.final_byte) begin
          state_next = bpbcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpbcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bpbcd_pkg::ST_IDLE;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  assign busy = (state != bpbcd_pkg::ST_IDLE);

endmodule

@@ hw/rtl/bpbcd_datapath.sv @@
// Binary shift register, BCD digit register, byte slicer and output registers.
module bpbcd_datapath #(
  parameter int MAX_DIGITS = bpbcd_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpbcd_pkg::cmd_t                     cmd,
  input  logic [bpbcd_pkg::VALUE_W-1:0]       value,
  input  logic [bpbcd_pkg::COUNT_W-1:0]       digit_count,
  output bpbcd_pkg::status_t                  status,
  output logic                                strobe,
  output logic [bpbcd_pkg::BYTE_W-1:0]        bcd_byte,
  output logic [bpbcd_pkg::INDEX_W-1:0]       byte_index,
  output logic                                last,
  output logic                                truncated
);

  localparam int DW = bpbcd_pkg::DIGIT_W;

  logic [bpbcd_pkg::VALUE_W-1:0] bin;
  logic [bpbcd_pkg::BCD_W-1:0]   bcd, bcd_adj;
  logic [bpbcd_pkg::COUNT_W-1:0] num_digits, count_clamped;
  logic [bpbcd_pkg::INDEX_W-1:0] byte_idx, num_bytes;
  logic                          has_hi, trunc_now;
  logic [DW-1:0]                 hi_digit;

  always_comb begin
    if (digit_count == '0) begin
      count_clamped = bpbcd_pkg::COUNT_W'(1);
    end else if (digit_count > bpbcd_pkg::COUNT_W'(MAX_DIGITS)) begin
      count_clamped = bpbcd_pkg::COUNT_W'(MAX_DIGITS);
    end else begin
      count_clamped = digit_count;
    end
  end

  always_comb begin
    for (int i = 0; i < bpbcd_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i*DW +: DW] = bpbcd_pkg::dabble_digit(bcd[i*DW +: DW]);
    end
  end

  assign num_bytes         = bpbcd_pkg::INDEX_W'((num_digits + 1'b1) >> 1);
  assign status.final_byte = (byte_idx == num_bytes - 1'b1);
  assign has_hi            = ({1'b0, byte_idx} << 1) + 1'b1 < num_digits;
  assign hi_digit          = has_hi ? bcd[2*DW-1:DW] : '0;
  assign trunc_now         = has_hi ? (bcd[bpbcd_pkg::BCD_W-1:2*DW] != '0)
                                    : (bcd[bpbcd_pkg::BCD_W-1:DW] != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin        <= value;
      bcd        <= '0;
      num_digits <= count_clamped;
      byte_idx   <= '0;
    end else if (cmd.shift) begin
      bin <= bin << 1;
      bcd <= {bcd_adj[bpbcd_pkg::BCD_W-2:0], bin[bpbcd_pkg::VALUE_W-1]};
    end else if (cmd.emit) begin
      bcd      <= bcd >> (2*DW);
      byte_idx <= byte_idx + 1'b1;
    end
  end

  // Output registers: payload follows the strobe by construction.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bcd_byte   <= {hi_digit, bcd[DW-1:0]};
      byte_index <= byte_idx;
      last       <= status.final_byte;
      truncated  <= status.final_byte & trunc_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

@@ hw/rtl/binary_to_packed_bcd_unit.sv @@
// Top level of the 64-bit binary to packed BCD converter.
// Sequence: load the operand, run double dabble bit by bit, then emit one byte per cycle;
// a run carries ceil(n/2) bytes for n digits, low pair first.
// A new transaction is taken only after the final byte of the previous run has gone out.
// Reset (rst, synchronous): return to idle, drop any conversion, clear strobe.
// Results are strobed for one cycle each; the receiver cannot stall them.
module binary_to_packed_bcd_unit #(
  parameter int MAX_DIGITS = bpbcd_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpbcd_pkg::VALUE_W-1:0] value,
  input  logic [bpbcd_pkg::COUNT_W-1:0] digit_count,
  output logic                          strobe,
  output logic [bpbcd_pkg::BYTE_W-1:0]  bcd_byte,
  output logic [bpbcd_pkg::INDEX_W-1:0] byte_index,
  output logic                          last,
  output logic                          truncated
);

  // Command and status between the sequencer and the datapath.
  bpbcd_pkg::cmd_t    cmd;
  bpbcd_pkg::status_t status;

  // Sequencer: accept a transaction when idle, advance through the shift
  // steps, then hold in the emit state until the final byte goes out.
  bpbcd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: capture the operand, run double dabble one bit per cycle,
  // then slice the digit register into packed bytes, low pair first.
  bpbcd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (value),
    .digit_count (digit_count),
    .status      (status),
    .strobe      (strobe),
    .bcd_byte    (bcd_byte),
    .byte_index  (byte_index),
    .last        (last),
    .truncated   (truncated)
  );

  // A byte only goes out while a conversion is in progress.
  a_strobe_in_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe outside a conversion");

  // Accepting a transaction makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a conversion");

  // Bytes of one run come out back to back until the final one.
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside a byte run");

  // Truncation is only flagged on the final byte.
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && truncated) |-> last)
    else $error("truncation flagged before the final byte");

  // Byte index advances by one within a run.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (byte_index == $past(byte_index) + 1'b1))
    else $error("byte index did not advance");

endmodule

@@ test/tb_binary_to_packed_bcd_unit.sv @@
// Self-checking testbench for the binary to packed BCD converter.
`timescale 1ns / 1ps

module tb_binary_to_packed_bcd_unit;

  localparam int MAX_DIGITS    = bpbcd_pkg::DEFAULT_MAX_DIGITS;
  localparam int RANDOM_ITEMS  = 310;
  localparam int CALM_TAIL     = 40;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 25;

  localparam logic [bpbcd_pkg::VALUE_W-1:0] ALL_ONES = {bpbcd_pkg::VALUE_W{1'b1}};

  typedef struct {
    logic [bpbcd_pkg::BYTE_W-1:0]  digits;
    logic [bpbcd_pkg::INDEX_W-1:0] pos;
    logic                          is_last;
    logic                          trunc;
  } bcd_result_t;

  // A row with has_answer set carries its single byte typed in; other rows
  // are checked against the predictor.
  typedef struct {
    logic [bpbcd_pkg::VALUE_W-1:0] val;
    logic [bpbcd_pkg::COUNT_W-1:0] cnt;
    bit                            has_answer;
    logic [bpbcd_pkg::BYTE_W-1:0]  answer_digits;
    logic                          answer_trunc;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [bpbcd_pkg::VALUE_W-1:0] value = '0;
  logic [bpbcd_pkg::COUNT_W-1:0] digit_count = '0;
  logic                          busy;
  logic                          strobe;
  logic [bpbcd_pkg::BYTE_W-1:0]  bcd_byte;
  logic [bpbcd_pkg::INDEX_W-1:0] byte_index;
  logic                          last;
  logic                          truncated;

  bcd_result_t pending_bytes[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{64'd0, 5'd1, 1'b1, 8'h00, 1'b0},
    '{64'd0, 5'd0, 1'b1, 8'h00, 1'b0},           // zero count acts as one digit
    '{64'd7, 5'd0, 1'b1, 8'h07, 1'b0},
    '{64'd9, 5'd1, 1'b1, 8'h09, 1'b0},
    '{64'd12, 5'd1, 1'b1, 8'h02, 1'b1},          // tens digit dropped
    '{64'd99, 5'd2, 1'b1, 8'h99, 1'b0},
    '{64'd100, 5'd2, 1'b1, 8'h00, 1'b1},
    '{64'd42, 5'd2, 1'b1, 8'h42, 1'b0},
    '{64'd5, 5'd2, 1'b1, 8'h05, 1'b0},           // upper digit is zero
    '{ALL_ONES, 5'd20, 1'b0, 8'h00, 1'b0},
    '{ALL_ONES, 5'd19, 1'b0, 8'h00, 1'b0},       // leading digit lost
    '{ALL_ONES, 5'd31, 1'b0, 8'h00, 1'b0},       // count saturates
    '{ALL_ONES, 5'd21, 1'b0, 8'h00, 1'b0},
    '{64'd0, 5'd20, 1'b0, 8'h00, 1'b0},
    '{64'd999, 5'd3, 1'b0, 8'h00, 1'b0},         // odd count, clean high nibble
    '{64'd12345, 5'd5, 1'b0, 8'h00, 1'b0},
    '{64'd123456789, 5'd9, 1'b0, 8'h00, 1'b0},
    '{64'd9999999999999999999, 5'd19, 1'b0, 8'h00, 1'b0},
    '{64'd10000000000000000000, 5'd19, 1'b0, 8'h00, 1'b0},
    '{64'h8000000000000000, 5'd20, 1'b0, 8'h00, 1'b0},
    '{64'd1234567890, 5'd10, 1'b0, 8'h00, 1'b0},
    '{64'h5555555555555555, 5'd31, 1'b0, 8'h00, 1'b0},
    '{64'hAAAAAAAAAAAAAAAA, 5'd16, 1'b0, 8'h00, 1'b0},
    '{64'd1, 5'd31, 1'b0, 8'h00, 1'b0},
    '{64'd987654321, 5'd8, 1'b0, 8'h00, 1'b0}
  };

  binary_to_packed_bcd_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .digit_count(digit_count),
    .strobe     (strobe),
    .bcd_byte   (bcd_byte),
    .byte_index (byte_index),
    .last       (last),
    .truncated  (truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one expected byte at the tail of the queue.
  function automatic void enqueue_byte(input bcd_result_t r);
    pending_bytes.insert(pending_bytes.size(), r);
  endfunction

  // Peel decimal digits off the low end, two per byte, and queue each byte.
  function automatic void predict_packed_bcd(input logic [bpbcd_pkg::VALUE_W-1:0] v,
                                             input logic [bpbcd_pkg::COUNT_W-1:0] cnt);
    logic [bpbcd_pkg::VALUE_W-1:0] rest;
    int unsigned                   n;
    int unsigned                   nbytes;
    logic [3:0]                    lo;
    logic [3:0]                    hi;
    bcd_result_t                   r;
    rest = v;
    n = cnt;
    if (n < 1) n = 1;
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    nbytes = (n + 1) / 2;
    for (int unsigned b = 0; b < nbytes; b++) begin
      lo = 4'(rest % 10);
      rest = rest / 10;
      hi = 4'd0;
      if (2 * b + 1 < n) begin
        hi = 4'(rest % 10);
        rest = rest / 10;
      end
      r.digits  = {hi, lo};
      r.pos     = bpbcd_pkg::INDEX_W'(b);
      r.is_last = (b + 1 == nbytes);
      r.trunc   = (b + 1 == nbytes) && (rest != 0);
      enqueue_byte(r);
    end
  endfunction

  function automatic logic [bpbcd_pkg::VALUE_W-1:0] pow10(input int k);
    logic [bpbcd_pkg::VALUE_W-1:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Mix wide random values with values near digit boundaries.
  function automatic logic [bpbcd_pkg::VALUE_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return {$urandom, $urandom};
    if (kind < 7) return {$urandom, $urandom} >> $urandom_range(0, 63);
    if (kind < 9) return pow10($urandom_range(0, 19)) + $urandom_range(0, 4) - 2;
    if ($urandom_range(0, 3) == 0) return ALL_ONES;
    return pow10($urandom_range(1, 19)) - 1;
  endfunction

  function automatic logic [bpbcd_pkg::COUNT_W-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return bpbcd_pkg::COUNT_W'($urandom_range(0, 31));
    return bpbcd_pkg::COUNT_W'($urandom_range(1, MAX_DIGITS));
  endfunction

  // Hold start until the unit takes the transaction; start stays high on return.
  task automatic issue(input logic [bpbcd_pkg::VALUE_W-1:0] v,
                       input logic [bpbcd_pkg::COUNT_W-1:0] cnt);
    start       <= 1'b1;
    value       <= v;
    digit_count <= cnt;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a short burst, sometimes lined up with the end of busy.
  task automatic idle_burst();
    start       <= 1'b0;
    value       <= {$urandom, $urandom};
    digit_count <= bpbcd_pkg::COUNT_W'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      do @(posedge clk); while (busy);
    end
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Check each strobed byte against the oldest expectation; watch for stalls.
  always @(posedge clk) begin
    bcd_result_t want;
    if (!rst) begin
      if ((start && !busy) || strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
      if (strobe) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h index %0d", $time, bcd_byte, byte_index);
          mismatches++;
        end else begin
          want = pending_bytes.pop_front();
          if (bcd_byte !== want.digits) begin
            $display("%0t: bcd_byte expected %h actual %h", $time, want.digits, bcd_byte);
            mismatches++;
          end
          if (byte_index !== want.pos) begin
            $display("%0t: byte_index expected %0d actual %0d", $time, want.pos,
                     byte_index);
            mismatches++;
          end
          if (last !== want.is_last) begin
            $display("%0t: last expected %b actual %b", $time, want.is_last, last);
            mismatches++;
          end
          if (truncated !== want.trunc) begin
            $display("%0t: truncated expected %b actual %b", $time, want.trunc,
                     truncated);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic [bpbcd_pkg::VALUE_W-1:0] v;
    logic [bpbcd_pkg::COUNT_W-1:0] cnt;
    bcd_result_t                   typed;
    bit                            calm;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: queue the typed answer where there is one.
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].val, directed_rows[i].cnt);
      if (directed_rows[i].has_answer) begin
        typed.digits  = directed_rows[i].answer_digits;
        typed.pos     = '0;
        typed.is_last = 1'b1;
        typed.trunc   = directed_rows[i].answer_trunc;
        enqueue_byte(typed);
      end else begin
        predict_packed_bcd(directed_rows[i].val, directed_rows[i].cnt);
      end
      if (i % 3 == 1) idle_burst();
    end
    drain();

    // Random part: idle in alternating stretches, none in the closing stretch.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      v   = pick_value();
      cnt = pick_count();
      issue(v, cnt);
      predict_packed_bcd(v, cnt);
      calm = (i >= RANDOM_ITEMS - CALM_TAIL) || ((i / 40) % 2 == 1);
      if (i == 100 || i == 200) drain();
      else if (!calm && $urandom_range(0, 2) == 0) idle_burst();
    end
    start <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
